// File: hdl/bounded_list_search_delete_assert.svh
// Assertion macros shared by the list search and delete block.
// Each macro reports through $error and is compiled away for synthesis.
`ifndef BOUNDED_LIST_SEARCH_DELETE_ASSERT_SVH
`define BOUNDED_LIST_SEARCH_DELETE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define BLSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("list block assertion failed");
// Checked property that also holds during reset.
`define BLSD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("list block assertion failed");
`else
`define BLSD_ASSERT(lbl, clk, rst, prop)
`define BLSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/blsd_pkg.sv
package blsd_pkg;

   // Capacity of the list and the widths that follow from it.
   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Field widths of the request and response.
   localparam int CMD_W    = 3;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int MATCH_W  = 6;
   localparam int LEN_W    = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR      = 3'd0,
      CMD_INS_FRONT  = 3'd1,
      CMD_INS_BACK   = 3'd2,
      CMD_DEL_FRONT  = 3'd3,
      CMD_DEL_BACK   = 3'd4,
      CMD_SEARCH     = 3'd5,
      CMD_SEARCH_DEL = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic capture;      // register the compare result of each cell
      logic shift_right;  // every cell takes its front neighbor's value
      logic shift_left;   // every cell takes its back neighbor's value
      logic remove_match; // cells at or behind the first match shift left
      logic append;       // the cell at the current length loads the key
   } cell_ctrl_type;

endpackage

// File: hdl/blsd_if.sv
// Request channel: one list command with its value or key.
interface blsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [blsd_pkg::CMD_W-1:0]  command;
   logic signed [blsd_pkg::VAL_W-1:0] value;

   modport source (output valid, command, value, input ready);
   modport sink (input valid, command, value, output ready);
endinterface

// Response channel: status, first match position and new length.
interface blsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [blsd_pkg::STATUS_W-1:0] status;
   logic [blsd_pkg::MATCH_W-1:0]  match_index;
   logic [blsd_pkg::LEN_W-1:0]    length;

   modport source (output valid, status, match_index, length, input ready);
   modport sink (input valid, status, match_index, length, output ready);
endinterface

// File: hdl/blsd_cell.sv
// One list position: holds one element, compares it with the key and
// moves data to or from its neighbors.
module blsd_cell (
   input  logic                          clock,
   input  logic [blsd_pkg::IDX_W-1:0]    pos,
   input  logic [blsd_pkg::CNT_W-1:0]    count,
   input  blsd_pkg::cell_ctrl_type       ctrl,
   input  logic                          below_match,
   input  logic [blsd_pkg::VAL_W-1:0]    key,
   input  logic [blsd_pkg::VAL_W-1:0]    front_data,
   input  logic [blsd_pkg::VAL_W-1:0]    back_data,
   output logic [blsd_pkg::VAL_W-1:0]    data,
   output logic                          hit
);

   logic [blsd_pkg::VAL_W-1:0] data_ff, data_in;
   logic                       hit_ff, hit_in;
   logic                       occupied;
   logic                       at_tail;

   // The cell holds an element when its position is below the length.
   assign occupied = blsd_pkg::CNT_W'(pos) < count;
   assign at_tail  = blsd_pkg::CNT_W'(pos) == count;

   // Compare result is sampled when a request is taken.
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = occupied && (data_ff == key);
      end
   end

   // Data movement for the executed command.
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_right) begin
         data_in = front_data;
      end else if (ctrl.shift_left || (ctrl.remove_match && !below_match)) begin
         data_in = back_data;
      end else if (ctrl.append && at_tail) begin
         data_in = key;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// File: hdl/bounded_list_search_delete.sv
// Bounded ordered list of signed 32-bit values held in a row of cells.
// Requests arrive on req_chan (command, value) with a valid/ready handshake;
// each request yields exactly one response on rsp_chan (status, match_index,
// length), in request order.
// A request is handled in a compare step and an execute step. In the compare
// step, every cell compares its element with the key and registers the
// outcome; in the execute step, a priority pick over the cell hits finds the
// first match, the cells shift or load as the command needs, and the response
// is written into the output register. No new request is taken during the
// execute step.
// A new request can be taken in the same cycle as the previous response;
// a request is held off for as long as the receiver stalls that response,
// and the list itself does not change while it waits.
// Synchronous active-high reset empties the list and drops any pending
// response; element storage itself is not cleared and needs no sweep.
`include "bounded_list_search_delete_assert.svh"
module bounded_list_search_delete (
   input  logic        clock,
   input  logic        reset,
   blsd_req_if.sink    req_chan,
   blsd_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   localparam int D = blsd_pkg::LIST_DEPTH;

   state_type                          state_ff, state_in;
   blsd_pkg::cmd_type                  cmd_ff, cmd_in;
   logic [blsd_pkg::VAL_W-1:0]         key_ff, key_in;
   logic [blsd_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   blsd_pkg::status_type               status_ff, status_in;
   logic [blsd_pkg::MATCH_W-1:0]       match_ff, match_in;
   logic [blsd_pkg::LEN_W-1:0]         length_ff, length_in;

   blsd_pkg::cell_ctrl_type            ctrl;
   logic [D-1:0]                       hits;
   logic [D-1:0]                       first_hit;
   logic [D-1:0]                       below;
   logic [blsd_pkg::IDX_W-1:0]         first_idx;
   logic                               any_hit;
   logic                               list_empty;
   logic                               list_full;
   logic                               req_accept;
   logic [blsd_pkg::VAL_W-1:0]         cell_data [D];
   logic [blsd_pkg::VAL_W-1:0]         cmp_key;
   logic [blsd_pkg::IDX_W+blsd_pkg::MATCH_W-1:0] idx_wide;
   logic [blsd_pkg::CNT_W+blsd_pkg::LEN_W-1:0]   len_wide;

   // Handshake: take a request when idle and the output register is free.
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign cmp_key = (state_ff == S_IDLE) ? req_chan.value : key_ff;

   // Row of cells; the front cell sees the key as its front neighbor.
   for (genvar i = 0; i < D; i++) begin : g_cell
      logic [blsd_pkg::VAL_W-1:0] front_d, back_d;
      if (i == 0) begin : g_front
         assign front_d = key_ff;
      end else begin : g_mid_front
         assign front_d = cell_data[i-1];
      end
      if (i == D - 1) begin : g_back
         assign back_d = cell_data[i];
      end else begin : g_mid_back
         assign back_d = cell_data[i+1];
      end
      blsd_cell u_cell (
         .clock       (clock),
         .pos         (blsd_pkg::IDX_W'(i)),
         .count       (count_ff),
         .ctrl        (ctrl),
         .below_match (below[i]),
         .key         (cmp_key),
         .front_data  (front_d),
         .back_data   (back_d),
         .data        (cell_data[i]),
         .hit         (hits[i])
      );
   end

   // First match: isolate the lowest set hit and the positions before it.
   assign any_hit   = |hits;
   assign first_hit = hits & (~hits + D'(1));
   assign below     = first_hit - D'(1);

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < D; i++) begin
         first_idx = first_idx | (first_hit[i] ? blsd_pkg::IDX_W'(i) : '0);
      end
   end

   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == blsd_pkg::CNT_W'(D));

   // Request capture when idle and command execution in the execute state.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      match_in     = match_ff;
      length_in    = length_ff;
      ctrl         = '0;
      idx_wide     = '0;
      len_wide     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ctrl.capture = 1'b1;
               cmd_in       = blsd_pkg::cmd_type'(req_chan.command);
               key_in       = req_chan.value;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = blsd_pkg::STATUS_OK;
            idx_wide  = '0;
            case (cmd_ff)
               blsd_pkg::CMD_CLEAR: begin
                  count_in = '0;
               end
               blsd_pkg::CMD_INS_FRONT: begin
                  if (list_full) begin
                     status_in = blsd_pkg::STATUS_FULL;
                  end else begin
                     ctrl.shift_right = 1'b1;
                     count_in         = count_ff + blsd_pkg::CNT_W'(1);
                  end
               end
               blsd_pkg::CMD_INS_BACK: begin
                  if (list_full) begin
                     status_in = blsd_pkg::STATUS_FULL;
                  end else begin
                     ctrl.append = 1'b1;
                     count_in    = count_ff + blsd_pkg::CNT_W'(1);
                  end
               end
               blsd_pkg::CMD_DEL_FRONT: begin
                  if (list_empty) begin
                     status_in = blsd_pkg::STATUS_EMPTY;
                  end else begin
                     ctrl.shift_left = 1'b1;
                     count_in        = count_ff - blsd_pkg::CNT_W'(1);
                  end
               end
               blsd_pkg::CMD_DEL_BACK: begin
                  if (list_empty) begin
                     status_in = blsd_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - blsd_pkg::CNT_W'(1);
                  end
               end
               blsd_pkg::CMD_SEARCH, blsd_pkg::CMD_SEARCH_DEL: begin
                  if (list_empty) begin
                     status_in = blsd_pkg::STATUS_EMPTY;
                  end else if (!any_hit) begin
                     status_in = blsd_pkg::STATUS_NOT_FOUND;
                  end else begin
                     idx_wide = {{blsd_pkg::MATCH_W{1'b0}}, first_idx};
                     if (cmd_ff == blsd_pkg::CMD_SEARCH_DEL) begin
                        ctrl.remove_match = 1'b1;
                        count_in          = count_ff - blsd_pkg::CNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
            len_wide     = {{blsd_pkg::LEN_W{1'b0}}, count_in};
            match_in     = idx_wide[blsd_pkg::MATCH_W-1:0];
            length_in    = len_wide[blsd_pkg::LEN_W-1:0];
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      match_ff  <= match_in;
      length_ff <= length_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.match_index = match_ff;
   assign rsp_chan.length      = length_ff;

   // The length never goes past the capacity.
   `BLSD_ASSERT(a_count_bound, clock, reset, count_ff <= blsd_pkg::CNT_W'(D))
   // A taken request is executed in the following cycle.
   `BLSD_ASSERT(a_accept_exec, clock, reset, req_accept |=> state_ff == S_EXEC)
   // A new response only appears right after an execute cycle.
   `BLSD_ASSERT(a_rsp_after_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
   // A successful search-and-delete shortens the list by one.
   `BLSD_ASSERT(a_del_shrinks, clock, reset, (state_ff == S_EXEC && cmd_ff == blsd_pkg::CMD_SEARCH_DEL && any_hit) |=> count_ff == $past(count_ff) - blsd_pkg::CNT_W'(1))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import blsd_pkg::*;

   localparam int RANDOM_ITEMS = 750;
   localparam int STEADY_TAIL  = 150;

   typedef logic signed [VAL_W-1:0] elem_t;

   // One expected response.
   typedef struct {
      status_type           status;
      logic [MATCH_W-1:0]   match_index;
      logic [LEN_W-1:0]     length;
   } list_result_t;

   typedef enum int {EP_GROW, EP_SHRINK, EP_MIXED, EP_NOISE} episode_mode_t;

   // Tracks the list contents and the responses still owed by the block.
   class list_scoreboard;
      elem_t        contents[$];
      list_result_t expected_q[$];
      int           errors;
      int           requests;
      int           status_count[4];
      int           middle_deletes;
      int           clears;
      int           peak_length;

      function int outstanding();
         return expected_q.size();
      endfunction

      // Apply an accepted request to the list and queue the response it must give.
      function void note_request(cmd_type cmd, elem_t key);
         list_result_t r;
         int           pos;
         int           i;
         r.status      = STATUS_OK;
         r.match_index = '0;
         pos           = -1;
         requests++;
         case (cmd)
            CMD_CLEAR: begin
               contents.delete();
               clears++;
            end
            CMD_INS_FRONT, CMD_INS_BACK: begin
               if (contents.size() >= LIST_DEPTH)
                  r.status = STATUS_FULL;
               else if (cmd == CMD_INS_FRONT)
                  contents.push_front(key);
               else
                  contents.push_back(key);
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
               if (contents.size() == 0)
                  r.status = STATUS_EMPTY;
               else if (cmd == CMD_DEL_FRONT)
                  void'(contents.pop_front());
               else
                  void'(contents.pop_back());
            end
            CMD_SEARCH, CMD_SEARCH_DEL: begin
               if (contents.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  for (i = 0; i < contents.size() && pos < 0; i++)
                     if (contents[i] == key)
                        pos = i;
                  if (pos < 0) begin
                     r.status = STATUS_NOT_FOUND;
                  end else begin
                     r.match_index = pos[MATCH_W-1:0];
                     if (cmd == CMD_SEARCH_DEL) begin
                        if (pos > 0 && pos < contents.size() - 1)
                           middle_deletes++;
                        contents.delete(pos);
                     end
                  end
               end
            end
            default: ;
         endcase
         r.length = LEN_W'(contents.size());
         if (contents.size() > peak_length)
            peak_length = contents.size();
         status_count[r.status]++;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_response(logic [STATUS_W-1:0] status, logic [MATCH_W-1:0] match_index,
                          logic [LEN_W-1:0] length);
         list_result_t want;
         if (expected_q.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = expected_q.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("status got %0d, expected %0d", status, want.status));
            if (match_index !== want.match_index)
               report_mismatch($sformatf("match_index got %0d, expected %0d",
                                         match_index, want.match_index));
            if (length !== want.length)
               report_mismatch($sformatf("length got %0d, expected %0d", length, want.length));
         end
      endtask

      task final_check();
         if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_q.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic steady = 1'b0;
   int   random_sent = 0;

   list_scoreboard sb;

   blsd_req_if req_bus();
   blsd_rsp_if rsp_bus();

   bounded_list_search_delete u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Note every accepted request and check every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_request(cmd_type'(req_bus.command), req_bus.value);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_response(rsp_bus.status, rsp_bus.match_index, rsp_bus.length);
      end
   end

   // The receiver stalls in random bursts until the steady tail of the run.
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!steady && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Present one request, possibly after an idle burst, and hold it until taken.
   task automatic send_request(cmd_type cmd, elem_t key);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.value   <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic cmd_type pick_command(episode_mode_t mode);
      int r;
      int w[7];
      r = $urandom_range(0, 99);
      case (mode)
         EP_GROW:   w = '{1, 32, 32, 4, 4, 15, 12};
         EP_SHRINK: w = '{1, 10, 10, 22, 22, 12, 23};
         default:   w = '{2, 20, 20, 11, 11, 18, 18};
      endcase
      for (int c = 0; c < 7; c++) begin
         if (r < w[c])
            return cmd_type'(c);
         r -= w[c];
      end
      return CMD_SEARCH;
   endfunction

   // A run of commands; outside noise mode, values mostly come from a small pool, so searches hit.
   task automatic run_episode(episode_mode_t mode, int count);
      elem_t   pool[6];
      elem_t   key;
      cmd_type cmd;
      int      i;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = $urandom_range(0, 3);
      for (i = 3; i < 6; i++)
         pool[i] = $urandom;
      for (i = 0; i < count; i++) begin
         if (mode == EP_NOISE) begin
            cmd = cmd_type'($urandom_range(0, 6));
            key = $urandom;
         end else begin
            cmd = pick_command(mode);
            key = ($urandom_range(0, 4) == 0) ? elem_t'($urandom) : pool[$urandom_range(0, 5)];
         end
         send_request(cmd, key);
         random_sent++;
      end
   endtask

   // Fill the list to capacity, push against the limit, then work on the full list.
   task automatic fill_to_capacity();
      elem_t key;
      elem_t back_key;
      elem_t mid_key;
      int    i;
      send_request(CMD_CLEAR, $urandom);
      for (i = 0; i < LIST_DEPTH; i++) begin
         key = $urandom;
         if (i == LIST_DEPTH / 2)
            mid_key = key;
         back_key = key;
         send_request(CMD_INS_BACK, key);
      end
      send_request(CMD_INS_FRONT, $urandom);
      send_request(CMD_INS_BACK, $urandom);
      send_request(CMD_SEARCH, back_key);
      send_request(CMD_SEARCH_DEL, mid_key);
      send_request(CMD_INS_FRONT, $urandom);
      send_request(CMD_INS_BACK, $urandom);
      send_request(CMD_DEL_BACK, $urandom);
      send_request(CMD_DEL_FRONT, $urandom);
   endtask

   // Stimulus: directed corner cases, a full-list pass, then random episodes.
   initial begin
      episode_mode_t mode;
      int            len;
      int            pick;
      sb = new();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_CLEAR;
      req_bus.value   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty-list commands, extreme values, matches at front, middle and back.
      send_request(CMD_CLEAR, 32'sd0);
      send_request(CMD_SEARCH, 32'sd0);
      send_request(CMD_SEARCH_DEL, 32'sd0);
      send_request(CMD_DEL_FRONT, 32'sd0);
      send_request(CMD_DEL_BACK, 32'sd0);
      send_request(CMD_INS_FRONT, 32'h7fff_ffff);
      send_request(CMD_INS_BACK, 32'h8000_0000);
      send_request(CMD_INS_BACK, 32'sd0);
      send_request(CMD_INS_FRONT, 32'hffff_ffff);
      send_request(CMD_SEARCH, 32'h8000_0000);
      send_request(CMD_SEARCH, 32'sd12345);
      send_request(CMD_SEARCH_DEL, 32'h7fff_ffff);
      send_request(CMD_SEARCH_DEL, 32'sd0);
      send_request(CMD_SEARCH_DEL, 32'hffff_ffff);
      // A sole element that does not match must stay.
      send_request(CMD_SEARCH_DEL, 32'sd5);
      send_request(CMD_SEARCH, 32'h8000_0000);
      send_request(CMD_DEL_BACK, 32'sd0);
      // Duplicates: the first occurrence is the one found and removed.
      send_request(CMD_INS_BACK, 32'sd1);
      send_request(CMD_INS_BACK, 32'sd1);
      send_request(CMD_SEARCH, 32'sd1);
      send_request(CMD_SEARCH_DEL, 32'sd1);
      send_request(CMD_DEL_FRONT, 32'sd0);
      send_request(CMD_DEL_FRONT, 32'sd0);
      send_request(CMD_INS_FRONT, 32'sd3);
      send_request(CMD_CLEAR, 32'sd0);

      // Hold off once until every response has come back.
      drain_responses();
      fill_to_capacity();
      drain_responses();

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - STEADY_TAIL)
            steady = 1'b1;
         len = $urandom_range(20, 90);
         if (len > RANDOM_ITEMS - random_sent)
            len = RANDOM_ITEMS - random_sent;
         pick = $urandom_range(0, 9);
         if (pick < 3)
            mode = EP_GROW;
         else if (pick < 5)
            mode = EP_SHRINK;
         else if (pick < 9)
            mode = EP_MIXED;
         else
            mode = EP_NOISE;
         run_episode(mode, len);
         if (!steady && $urandom_range(0, 5) == 0)
            drain_responses();
      end

      // Let the last responses come back, then wait for strays before the final check.
      drain_responses();
      repeat (8) @(posedge clock);
      sb.final_check();

      $display("Ran %0d requests (%0d random): %0d ok, %0d empty, %0d not found, %0d full.",
               sb.requests, random_sent, sb.status_count[STATUS_OK],
               sb.status_count[STATUS_EMPTY], sb.status_count[STATUS_NOT_FOUND],
               sb.status_count[STATUS_FULL]);
      $display("Peak length %0d, %0d middle removals by search-and-delete, %0d clears.",
               sb.peak_length, sb.middle_deletes, sb.clears);
      if (sb.errors == 0)
         $display("** bounded_list_search_delete: PASSED **");
      else
         $display("** bounded_list_search_delete: FAILED **");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses outstanding.", sb.outstanding());
      $display("** bounded_list_search_delete: FAILED **");
      $finish;
   end

endmodule
